>>> rtl/core/csrs_pkg.sv
// shared types and constants for the compressed-sparse-row matrix store
// no dependencies; imported by csrs_check and csr_sparse_matrix_store
package csrs_pkg;

  // fixed field widths at the block boundary
  localparam int OP_W     = 2;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 12;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // parameter defaults
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int MAX_NONZEROS_DEF = 4096;
  localparam int VALUE_BITS_DEF   = 32;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 11'd1024;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN
  } fsm_t;

  // outcome of the bound, order and capacity checks
  typedef struct packed {
    logic idx_bad;
    logic order_bad;
    logic full;
  } chk_t;

endpackage

>>> rtl/core/csrs_check.sv
// index, order and capacity checks for an incoming transfer
// depends on csrs_pkg
module csrs_check #(
  parameter int MAX_ROWS     = csrs_pkg::MAX_ROWS_DEF,
  parameter int MAX_NONZEROS = csrs_pkg::MAX_NONZEROS_DEF
) (
  input  logic [csrs_pkg::ROW_W-1:0]        row,
  input  logic [csrs_pkg::COL_W-1:0]        col,
  input  logic [csrs_pkg::CFG_W-1:0]        num_rows,
  input  logic [csrs_pkg::CFG_W-1:0]        num_cols,
  input  logic [csrs_pkg::ROW_W-1:0]        last_row,
  input  logic [csrs_pkg::COL_W-1:0]        last_col,
  input  logic                              any_loaded,
  input  logic [$clog2(MAX_NONZEROS+1)-1:0] entry_count,
  output csrs_pkg::chk_t                    chk
);
  import csrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_NONZEROS + 1);

  logic row_ok;
  logic col_ok;

  // rows are bounded by both the register and the row table depth
  assign row_ok = (32'(row) < 32'(MAX_ROWS)) && (CFG_W'(row) < num_rows);
  assign col_ok = CFG_W'(col) < num_cols;

  assign chk.idx_bad   = !(row_ok && col_ok);
  assign chk.order_bad = any_loaded &&
                         ((row < last_row) || ((row == last_row) && (col < last_col)));
  assign chk.full      = entry_count >= CNT_W'(MAX_NONZEROS);

endmodule

>>> rtl/core/csr_sparse_matrix_store.sv
// compressed-sparse-row matrix store: row start table, entry memory and sequencer
// depends on csrs_pkg and csrs_check
//
// usage
//   command channel: start with in_op/in_row/in_col/in_value; a transfer is taken
//   at a clock edge where start is high and busy is low
//   result channel: out_valid pulses for one cycle with out_status, out_value_out
//   and out_offset; every command gives exactly one result and the receiver
//   cannot stall, so nothing is ever held back
//   config: cfg_wr_en/cfg_index/cfg_wdata write num_rows (0) or num_cols (1);
//   the host must write only while the block is idle, the block does not enforce it
// timing
//   clear, append and any rejected command: result in the cycle after the
//   transfer, busy stays low, so one command per cycle
//   lookup/update: one row table read, then one entry memory read per entry
//   scanned, one at a time through the single read port of the entry memory;
//   an empty row needs only the row table read; busy stays high until the result
// storage
//   entries carry their row as a tag, so a row is the run of tagged entries
//   from its start below the fill count; no clearing pass, clear and reset
//   just zero the fill count and append history
//   reset restores num_rows and num_cols to 1024
module csr_sparse_matrix_store #(
  parameter int MAX_ROWS     = csrs_pkg::MAX_ROWS_DEF,
  parameter int MAX_NONZEROS = csrs_pkg::MAX_NONZEROS_DEF,
  parameter int VALUE_BITS   = csrs_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [csrs_pkg::OP_W-1:0]         in_op,
  input  logic [csrs_pkg::ROW_W-1:0]        in_row,
  input  logic [csrs_pkg::COL_W-1:0]        in_col,
  input  logic [csrs_pkg::DATA_W-1:0]       in_value,
  // result channel
  output logic                              out_valid,
  output logic [csrs_pkg::STATUS_W-1:0]     out_status,
  output logic [csrs_pkg::DATA_W-1:0]       out_value_out,
  output logic [csrs_pkg::OFFSET_W-1:0]     out_offset,
  // config port
  input  logic                              cfg_wr_en,
  input  logic [csrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csrs_pkg::CFG_W-1:0]        cfg_wdata
);
  import csrs_pkg::*;

  localparam int RA_W  = $clog2(MAX_ROWS);          // row table address
  localparam int PW    = $clog2(MAX_NONZEROS);      // entry position
  localparam int CNT_W = $clog2(MAX_NONZEROS + 1);  // fill count
  localparam int ENT_W = ROW_W + COL_W + VALUE_BITS;

  // ---------------------------------------------------------------------------
  // memories: row start table and tagged entry store
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    rs_mem [MAX_ROWS];
  logic [ENT_W-1:0] ent_mem [MAX_NONZEROS];

  logic             rs_we, rs_re;
  logic [RA_W-1:0]  rs_waddr, rs_raddr;
  logic [PW-1:0]    rs_wdata, rs_q;

  logic             ent_we, ent_re;
  logic [PW-1:0]    ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_q;

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    if (rs_re) begin
      rs_q <= rs_mem[rs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_raddr];
    end
  end

  // entry word fields
  logic [ROW_W-1:0]      ent_row;
  logic [COL_W-1:0]      ent_col;
  logic [VALUE_BITS-1:0] ent_val;
  assign {ent_row, ent_col, ent_val} = ent_q;

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic             any_loaded_r, any_loaded_nxt;
  logic [CFG_W-1:0] num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0] num_cols_r, num_cols_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers of the command in flight and of the result
  op_t                   op_r, op_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  status_t               status_r, status_nxt;
  logic [DATA_W-1:0]     vout_r, vout_nxt;
  logic [OFFSET_W-1:0]   off_r, off_nxt;

  logic             accept;
  chk_t             chk;
  logic [CNT_W-1:0] pos_inc;
  logic             hit_row;

  assign accept  = start && (state_r == S_IDLE);
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);
  assign hit_row = (ent_row == row_r);

  csrs_check #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_check (
    .row         (in_row),
    .col         (in_col),
    .num_rows    (num_rows_r),
    .num_cols    (num_cols_r),
    .last_row    (last_row_r),
    .last_col    (last_col_r),
    .any_loaded  (any_loaded_r),
    .entry_count (entry_count_r),
    .chk         (chk)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    last_row_nxt    = last_row_r;
    last_col_nxt    = last_col_r;
    any_loaded_nxt  = any_loaded_r;
    num_rows_nxt    = num_rows_r;
    num_cols_nxt    = num_cols_r;
    out_valid_nxt   = 1'b0;

    op_nxt     = op_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    off_nxt    = off_r;

    rs_we     = 1'b0;
    rs_re     = 1'b0;
    rs_waddr  = RA_W'(in_row);
    rs_raddr  = RA_W'(in_row);
    rs_wdata  = entry_count_r[PW-1:0];
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_waddr = entry_count_r[PW-1:0];
    ent_raddr = rs_q;
    ent_wdata = {in_row, in_col, VALUE_BITS'(in_value)};

    // register writes; the host must issue them only while idle, the block does not enforce it
    if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_ROWS: num_rows_nxt = cfg_wdata;
        REG_NUM_COLS: num_cols_nxt = cfg_wdata;
        default:      num_rows_nxt = num_rows_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_op);
          row_nxt    = in_row;
          col_nxt    = in_col;
          val_nxt    = VALUE_BITS'(in_value);
          status_nxt = ST_OK;
          vout_nxt   = '0;
          off_nxt    = '0;
          unique case (op_t'(in_op))
            OP_CLEAR: begin
              entry_count_nxt = '0;
              last_row_nxt    = '0;
              last_col_nxt    = '0;
              any_loaded_nxt  = 1'b0;
              out_valid_nxt   = 1'b1;
            end
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              priority if (chk.idx_bad || chk.order_bad) begin
                status_nxt = ST_BAD_IDX;
              end else if (chk.full) begin
                status_nxt = ST_FULL;
              end else begin
                // a new row opens at the current fill position
                rs_we           = !any_loaded_r || (in_row != last_row_r);
                ent_we          = 1'b1;
                off_nxt         = OFFSET_W'(entry_count_r);
                entry_count_nxt = entry_count_r + CNT_W'(1);
                last_row_nxt    = in_row;
                last_col_nxt    = in_col;
                any_loaded_nxt  = 1'b1;
              end
            end
            OP_LOOKUP, OP_UPDATE: begin
              if (chk.idx_bad) begin
                status_nxt    = ST_BAD_IDX;
                out_valid_nxt = 1'b1;
              end else begin
                rs_re     = 1'b1;
                state_nxt = S_START;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_START: begin
        // a start at or beyond the fill count means the row is empty
        if (CNT_W'(rs_q) < entry_count_r) begin
          ent_re    = 1'b1;
          ent_raddr = rs_q;
          pos_nxt   = rs_q;
          state_nxt = S_SCAN;
        end else begin
          status_nxt    = ST_ABSENT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SCAN: begin
        priority if (hit_row && (ent_col == col_r)) begin
          off_nxt       = OFFSET_W'(pos_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == OP_LOOKUP) begin
            vout_nxt = DATA_W'(ent_val);
          end else begin
            ent_we    = 1'b1;
            ent_waddr = pos_r;
            ent_wdata = {row_r, col_r, val_r};
          end
        end else if (hit_row && (pos_inc < entry_count_r)) begin
          // next entry of the same row
          ent_re    = 1'b1;
          ent_raddr = pos_inc[PW-1:0];
          pos_nxt   = pos_inc[PW-1:0];
        end else begin
          status_nxt    = ST_ABSENT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      last_row_r    <= '0;
      last_col_r    <= '0;
      any_loaded_r  <= 1'b0;
      num_rows_r    <= NUM_ROWS_RST;
      num_cols_r    <= NUM_COLS_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      last_row_r    <= last_row_nxt;
      last_col_r    <= last_col_nxt;
      any_loaded_r  <= any_loaded_nxt;
      num_rows_r    <= num_rows_nxt;
      num_cols_r    <= num_cols_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
    off_r    <= off_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value_out = vout_r;
  assign out_offset    = off_r;

endmodule
